FILE: src/lrs_pkg.sv
// shared types and constants for the life row step block
package lrs_pkg;

    localparam int ROW_W       = 64;
    localparam int WIDTH_W     = 7;
    localparam int MAX_WIDTH_D = 64;
    localparam int NBR_W       = 4;

    localparam logic [WIDTH_W-1:0] ACTIVE_WIDTH_RST = WIDTH_W'(64);
    localparam logic [NBR_W-1:0]   BORN_COUNT       = NBR_W'(3);
    localparam logic [NBR_W-1:0]   STAY_COUNT       = NBR_W'(2);

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    typedef struct packed {
        logic older;
        logic middle;
        logic above;
    } col_t;

endpackage

FILE: src/lrs_cell.sv
// one column cell: holds two stored rows' bits and computes the next state
module lrs_cell (
    input  logic          aclk,
    input  logic          load,
    input  logic          in_bit,
    input  logic          in_range,
    input  lrs_pkg::col_t left_col,
    input  lrs_pkg::col_t right_col,
    output lrs_pkg::col_t own_col,
    output logic          alive
);
    import lrs_pkg::*;

    logic             older_reg;
    logic             middle_reg;
    logic [NBR_W-1:0] nbr_count;

    always_ff @(posedge aclk) begin
        if (load) begin
            older_reg  <= middle_reg;
            middle_reg <= in_bit & in_range;
        end
    end

    assign own_col.older  = older_reg & in_range;
    assign own_col.middle = middle_reg & in_range;
    assign own_col.above  = in_bit & in_range;

    assign nbr_count = NBR_W'(left_col.older) + NBR_W'(own_col.older)
                     + NBR_W'(right_col.older) + NBR_W'(left_col.above)
                     + NBR_W'(own_col.above) + NBR_W'(right_col.above)
                     + NBR_W'(left_col.middle) + NBR_W'(right_col.middle);

    assign alive = in_range & ((nbr_count == BORN_COUNT)
                 | (own_col.middle & (nbr_count == STAY_COUNT)));

endmodule

FILE: src/life_row_step_core.sv
// top level of the life row step block: control, wrap selection, cell row
//
// One Conway Life generation (born on 3, survives on 2 or 3) over a strip of
// rows streamed in one row per item on the s_ channel. tuser marks the first
// (lower halo) row of a strip, tlast the last (upper halo) row. Once two rows
// are held, each further row yields the next state of the middle row on the
// m_ channel; its tlast copies the input tlast. Rows wrap horizontally over
// the active width written on the cfg channel (1..MAX_WIDTH, reset 64);
// cells at or above it read as dead and come out as zero.
// Throughput: one item per cycle while the receiver does not stall. A
// result is presented in the output register in the cycle after the row
// that causes it is accepted. Results come from one row of column cells
// that each hold the two stored rows and count neighbors from the adjacent
// cells combinationally. A stalled receiver holds the output register;
// s_tready then drops until the result is taken, with no item lost.
// Reset clears the rows held count, the output valid and the width to 64.
module life_row_step_core #(
    parameter int MAX_WIDTH = lrs_pkg::MAX_WIDTH_D
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lrs_pkg::WIDTH_W-1:0] cfg_data,   // active_width
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lrs_pkg::ROW_W-1:0]   s_tdata,    // row_cells
    input  logic                        s_tuser,    // first_row
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lrs_pkg::ROW_W-1:0]   m_tdata,    // next_cells
    output logic                        m_tlast
);
    import lrs_pkg::*;

    localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_WIDTH);

    logic [WIDTH_W-1:0]   width_reg;
    logic [1:0]           rows_held_reg;
    logic [1:0]           rows_held_next;
    logic                 m_tvalid_reg;
    logic [ROW_W-1:0]     m_tdata_reg;
    logic                 m_tlast_reg;

    logic                 accept;
    logic                 produce;
    logic [1:0]           held_eff;
    logic [WIDTH_W-1:0]   eff_w;
    logic [IDX_W-1:0]     w_last;
    logic [MAX_WIDTH-1:0] in_range;
    logic [MAX_WIDTH-1:0] alive_vec;
    col_t                 cols [MAX_WIDTH];

    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_tvalid_reg | m_tready;
    assign accept    = s_tvalid & s_tready;
    assign held_eff  = s_tuser ? HELD_NONE : rows_held_reg;
    assign produce   = accept & (held_eff == HELD_TWO);

    always_comb begin
        if (width_reg == '0) begin
            eff_w = WIDTH_W'(1);
        end else if (width_reg > MAX_W) begin
            eff_w = MAX_W;
        end else begin
            eff_w = width_reg;
        end
    end
    assign w_last = IDX_W'(eff_w - WIDTH_W'(1));

    always_comb begin
        case (held_eff)
            HELD_NONE: rows_held_next = HELD_ONE;
            HELD_ONE:  rows_held_next = HELD_TWO;
            default:   rows_held_next = HELD_TWO;
        endcase
        if (s_tlast) begin
            rows_held_next = HELD_NONE;
        end
    end

    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
        col_t left_col;
        col_t right_col;

        assign in_range[k] = (WIDTH_W'(k) < eff_w);

        if (k == 0) begin : g_left_wrap
            assign left_col = cols[w_last];
        end else begin : g_left
            assign left_col = cols[k-1];
        end

        if (k == MAX_WIDTH - 1) begin : g_right_wrap
            assign right_col = cols[0];
        end else begin : g_right
            assign right_col = (w_last == IDX_W'(k)) ? cols[0] : cols[k+1];
        end

        lrs_cell u_cell (
            .aclk      (aclk),
            .load      (accept),
            .in_bit    (s_tdata[k]),
            .in_range  (in_range[k]),
            .left_col  (left_col),
            .right_col (right_col),
            .own_col   (cols[k]),
            .alive     (alive_vec[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= ACTIVE_WIDTH_RST;
            rows_held_reg <= HELD_NONE;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                width_reg <= cfg_data;
            end
            if (accept) begin
                rows_held_reg <= rows_held_next;
            end
            if (s_tready) begin
                m_tvalid_reg <= produce;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            m_tdata_reg <= ROW_W'(alive_vec);
            m_tlast_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_held_reg != 2'd3)
        else $error("rows held count out of range");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> rows_held_reg == HELD_NONE)
        else $error("last row did not end the strip");

    a_result_made: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_tuser && rows_held_reg == HELD_TWO |=> m_tvalid_reg)
        else $error("missing result with two rows held");

    a_first_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser |=> !m_tvalid_reg)
        else $error("result made on first row of a strip");

endmodule

FILE: test/life_row_step_core_tb.sv
// testbench for life_row_step_core: directed table and random strips checked by a row predictor
`timescale 1ns / 1ps

module life_row_step_core_tb;
    import lrs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TOTAL_ROWS  = 1050;
    localparam int DRAIN_WAIT  = 8;
    localparam logic [ROW_W-1:0] ONES = '1;

    typedef struct {
        logic [WIDTH_W-1:0] width;
        logic [ROW_W-1:0]   cells;
        logic               first_row;
        logic               last_row;
        bit                 typed;
        logic [ROW_W-1:0]   typed_cells;
        logic               typed_last;
    } table_row_t;

    typedef struct {
        logic [ROW_W-1:0] cells;
        logic             last_flag;
    } row_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [WIDTH_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [ROW_W-1:0]     s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [ROW_W-1:0]     m_tdata;
    logic                 m_tlast;

    // predictor state
    logic [WIDTH_W-1:0]   width_reg = ACTIVE_WIDTH_RST;
    logic [ROW_W-1:0]     below_row = '0;
    logic [ROW_W-1:0]     center_row = '0;
    logic [1:0]           held_count = HELD_NONE;

    row_result_t          expected_rows[$];
    table_row_t           directed_rows[$];
    int                   mismatch_count = 0;
    int                   rows_sent = 0;
    int                   cycle_count = 0;
    bit                   calm = 1'b0;

    life_row_step_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int unsigned span_of(logic [WIDTH_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_WIDTH_D) return MAX_WIDTH_D;
        return 32'(v);
    endfunction

    function automatic logic [ROW_W-1:0] span_mask(int unsigned w);
        if (w >= ROW_W) return '1;
        return (ROW_W'(1) << w) - 1;
    endfunction

    function automatic logic [ROW_W-1:0] life_next(logic [ROW_W-1:0] below,
                                                   logic [ROW_W-1:0] mid,
                                                   logic [ROW_W-1:0] above,
                                                   int unsigned w);
        logic [ROW_W-1:0] res;
        int unsigned      lf;
        int unsigned      rt;
        int unsigned      n;
        res = '0;
        for (int unsigned k = 0; k < w; k++) begin
            lf = (k == 0) ? w - 1 : k - 1;
            rt = (k + 1 == w) ? 0 : k + 1;
            n = 0;
            n += below[lf];
            n += below[k];
            n += below[rt];
            n += above[lf];
            n += above[k];
            n += above[rt];
            n += mid[lf];
            n += mid[rt];
            if (mid[k])
                res[k] = (n == STAY_COUNT) || (n == BORN_COUNT);
            else
                res[k] = (n == BORN_COUNT);
        end
        return res;
    endfunction

    // advance the strip by one row, returns 1 when a result is made
    function automatic bit advance_strip(logic [ROW_W-1:0] cells, logic first_row,
                                         logic last_row, output row_result_t res);
        int unsigned      w;
        logic [ROW_W-1:0] mask;
        logic [ROW_W-1:0] row;
        bit               made;
        w = span_of(width_reg);
        mask = span_mask(w);
        row = cells & mask;
        made = 1'b0;
        res.cells = '0;
        res.last_flag = 1'b0;
        if (first_row) held_count = HELD_NONE;
        if (held_count == HELD_TWO) begin
            res.cells = life_next(below_row & mask, center_row & mask, row, w) & mask;
            res.last_flag = last_row;
            made = 1'b1;
            below_row = center_row;
            center_row = row;
        end else if (held_count == HELD_ONE) begin
            below_row = center_row;
            center_row = row;
            held_count = HELD_TWO;
        end else begin
            center_row = row;
            held_count = HELD_ONE;
        end
        if (last_row) held_count = HELD_NONE;
        return made;
    endfunction

    function automatic int unsigned draw_wait();
        if (calm) return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: return a;
            3, 4, 5: return a & b;
            6, 7:    return a | b;
            8:       return a & b & {$urandom, $urandom};
            default: return ($urandom_range(0, 1) == 0) ? '0 : ONES;
        endcase
    endfunction

    task automatic add_row(logic [WIDTH_W-1:0] w, logic [ROW_W-1:0] cells, logic first_row,
                           logic last_row, bit typed = 1'b0, logic [ROW_W-1:0] tc = '0,
                           logic tl = 1'b0);
        table_row_t r;
        r.width = w;
        r.cells = cells;
        r.first_row = first_row;
        r.last_row = last_row;
        r.typed = typed;
        r.typed_cells = tc;
        r.typed_last = tl;
        directed_rows.push_back(r);
    endtask

    task automatic send_row(logic [ROW_W-1:0] cells, logic first_row, logic last_row,
                            bit typed = 1'b0, logic [ROW_W-1:0] tc = '0, logic tl = 1'b0);
        int unsigned gap;
        row_result_t res;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cells;
        s_tuser  <= first_row;
        s_tlast  <= last_row;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rows_sent++;
        if (advance_strip(cells, first_row, last_row, res)) begin
            if (typed) begin
                res.cells = tc;
                res.last_flag = tl;
            end
            expected_rows.push_back(res);
        end
    endtask

    task automatic write_width(logic [WIDTH_W-1:0] v);
        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        width_reg = v;
    endtask

    // result side
    initial begin
        int unsigned stall;
        row_result_t want;
        m_tready <= 1'b0;
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected item, expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = expected_rows.pop_front();
                if (m_tdata !== want.cells) begin
                    $display("%0t: next_cells mismatch, expected %h actual %h",
                             $time, want.cells, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last_flag) begin
                    $display("%0t: final_result mismatch, expected %b actual %b",
                             $time, want.last_flag, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // row side
    initial begin
        logic [WIDTH_W-1:0] w;
        int unsigned        phase_len;
        int unsigned        strip_len;
        int unsigned        in_phase;
        logic [WIDTH_W-1:0] edge_widths[7];

        edge_widths = '{7'd0, 7'd1, 7'd2, 7'd63, 7'd64, 7'd65, 7'd127};
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // width 64 from reset
        add_row(7'd64, '0, 1'b1, 1'b0);
        add_row(7'd64, ONES, 1'b0, 1'b0);
        add_row(7'd64, '0, 1'b0, 1'b0, 1'b1, ONES, 1'b0);
        add_row(7'd64, ONES, 1'b0, 1'b0, 1'b1, '0, 1'b0);
        add_row(7'd64, ONES, 1'b0, 1'b1, 1'b1, '0, 1'b1);
        // new strip without a first-row flag after the last row
        add_row(7'd64, 64'h0000_0000_0000_0E00, 1'b0, 1'b0);
        add_row(7'd64, 64'h0000_0000_0000_0E00, 1'b0, 1'b0);
        add_row(7'd64, 64'h0000_0000_0000_0E00, 1'b0, 1'b0);
        // restart in the middle of a strip, wrap across cell 63 and cell 0
        add_row(7'd64, 64'h8000_0000_0000_0003, 1'b1, 1'b0);
        add_row(7'd64, 64'hC000_0000_0000_0001, 1'b0, 1'b0);
        add_row(7'd64, 64'h8000_0000_0000_0003, 1'b0, 1'b0);
        add_row(7'd64, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b1);
        add_row(7'd64, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b1);
        // one and two cells wide, upper bits ignored
        add_row(7'd1, ONES, 1'b1, 1'b0);
        add_row(7'd1, ONES, 1'b0, 1'b0);
        add_row(7'd1, ONES, 1'b0, 1'b1, 1'b1, '0, 1'b1);
        add_row(7'd2, 64'h3, 1'b1, 1'b0);
        add_row(7'd2, 64'hFFFF_FFFF_FFFF_FFFD, 1'b0, 1'b0);
        add_row(7'd2, 64'h2, 1'b0, 1'b1);
        // zero width acts as one
        add_row(7'd0, '0, 1'b1, 1'b0);
        add_row(7'd0, ONES, 1'b0, 1'b0);
        add_row(7'd0, '0, 1'b0, 1'b1, 1'b1, 64'h1, 1'b1);
        // width above the maximum acts as the maximum
        add_row(7'd127, ONES, 1'b1, 1'b0);
        add_row(7'd127, ONES, 1'b0, 1'b0);
        add_row(7'd127, ONES, 1'b0, 1'b1, 1'b1, '0, 1'b1);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].width != width_reg) write_width(directed_rows[i].width);
            send_row(directed_rows[i].cells, directed_rows[i].first_row,
                     directed_rows[i].last_row, directed_rows[i].typed,
                     directed_rows[i].typed_cells, directed_rows[i].typed_last);
        end

        while (rows_sent < TOTAL_ROWS) begin
            if ($urandom_range(0, 2) == 0)
                w = edge_widths[$urandom_range(0, 6)];
            else
                w = WIDTH_W'($urandom_range(0, 127));
            write_width(w);
            calm = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(40, 120);
            in_phase = 0;
            while (in_phase < phase_len) begin
                if ($urandom_range(0, 9) < 8) begin
                    if ($urandom_range(0, 9) == 0)
                        strip_len = $urandom_range(1, 2);
                    else
                        strip_len = $urandom_range(3, 14);
                    for (int unsigned j = 0; j < strip_len; j++)
                        send_row(rand_row(), j == 0, j + 1 == strip_len);
                    in_phase += strip_len;
                end else begin
                    send_row(rand_row(), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
                    in_phase++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
